// ===== rtl/ile_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ile_pkg
// Word types, command codes and status codes of the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int CMD_W = 3;
  localparam int POS_W = 11;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int LEN_W = 11;

  localparam logic [CMD_W-1:0] CMD_GET  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_HEAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TAIL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_AT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL  = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic                    hit;
    logic [ST_W-1:0]         status;
    logic [LEN_W-1:0]        length;
  } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/indexed_list_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of up to CAPACITY signed 32-bit values held in one memory.
// ----------------------------------------------------------------------------
// One command word in gives one result word out. A get reads the element
// store, then registers its result. An insert before the last element moves
// every later element up one slot, one memory entry per cycle through the
// one read port and one write port of the element store, then writes the new
// value; a delete moves the later elements down. Appends, deletes of the last
// element, ignored and dropped commands go straight to the result. The next
// command is taken once the previous result is registered.
// ----------------------------------------------------------------------------
module indexed_list_engine #(
  parameter int CAPACITY = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire ile_pkg::in_word_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      ile_pkg::out_word_t out_data
);
  import ile_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_GET   = 6'b000010,
    S_UP    = 6'b000100,
    S_PLACE = 6'b001000,
    S_DN    = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t                  state, state_next;
  logic [CW-1:0]           count, count_next;
  logic [AW-1:0]           wr, wr_next;
  logic [AW-1:0]           place, place_next;
  logic signed [VAL_W-1:0] val, val_next;
  out_word_t               res, res_next;
  logic                    out_load;

  logic                    we, re;
  logic [AW-1:0]           waddr, raddr;
  logic signed [VAL_W-1:0] wdata, rdata;

  logic [WW-1:0] pos_w, cnt_w, cap_w, ins_w;

  ile_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign pos_w    = WW'(in_data.position);
  assign cnt_w    = WW'(count);
  assign cap_w    = WW'(CAPACITY);

  always_comb begin
    case (in_data.cmd)
      CMD_HEAD: ins_w = '0;
      CMD_TAIL: ins_w = cnt_w;
      default:  ins_w = pos_w;
    endcase
  end

  always_comb begin
    state_next = state;
    count_next = count;
    wr_next    = wr;
    place_next = place;
    val_next   = val;
    res_next   = res;
    out_load   = 1'b0;
    we         = 1'b0;
    waddr      = wr;
    wdata      = rdata;
    re         = 1'b0;
    raddr      = wr;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          val_next            = in_data.value;
          res_next.read_value = '1;
          res_next.hit        = 1'b0;
          res_next.status     = ST_DONE;
          state_next          = S_FIN;
          case (in_data.cmd)
            CMD_GET: begin
              if (pos_w < cnt_w) begin
                re         = 1'b1;
                raddr      = pos_w[AW-1:0];
                state_next = S_GET;
              end else begin
                res_next.status = ST_RANGE;
              end
            end
            CMD_HEAD, CMD_TAIL, CMD_AT: begin
              if (ins_w > cnt_w) begin
                res_next.status = ST_RANGE;
              end else if (cnt_w >= cap_w) begin
                res_next.status = ST_FULL;
              end else if (ins_w == cnt_w) begin
                we         = 1'b1;
                waddr      = ins_w[AW-1:0];
                wdata      = in_data.value;
                count_next = count + CW'(1);
              end else begin
                place_next = ins_w[AW-1:0];
                wr_next    = count[AW-1:0];
                re         = 1'b1;
                raddr      = count[AW-1:0] - AW'(1);
                state_next = S_UP;
              end
            end
            CMD_DEL: begin
              if (pos_w >= cnt_w) begin
                res_next.status = ST_RANGE;
              end else if (pos_w == cnt_w - WW'(1)) begin
                count_next = count - CW'(1);
              end else begin
                wr_next    = pos_w[AW-1:0];
                re         = 1'b1;
                raddr      = pos_w[AW-1:0] + AW'(1);
                state_next = S_DN;
              end
            end
            default: begin
              res_next.status = ST_RANGE;
            end
          endcase
        end
      end
      S_GET: begin
        res_next.read_value = rdata;
        res_next.hit        = 1'b1;
        state_next          = S_FIN;
      end
      S_UP: begin
        we    = 1'b1;
        waddr = wr;
        wdata = rdata;
        if (wr - AW'(1) == place) begin
          state_next = S_PLACE;
        end else begin
          re      = 1'b1;
          raddr   = wr - AW'(1) - AW'(1);
          wr_next = wr - AW'(1);
        end
      end
      S_PLACE: begin
        we         = 1'b1;
        waddr      = place;
        wdata      = val;
        count_next = count + CW'(1);
        state_next = S_FIN;
      end
      S_DN: begin
        we    = 1'b1;
        waddr = wr;
        wdata = rdata;
        if (CW'(wr) + CW'(1) == count - CW'(1)) begin
          count_next = count - CW'(1);
          state_next = S_FIN;
        end else begin
          re      = 1'b1;
          raddr   = wr + AW'(1) + AW'(1);
          wr_next = wr + AW'(1);
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    res_next.length = LEN_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr    <= wr_next;
    place <= place_next;
    val   <= val_next;
    res   <= res_next;
    if (out_load) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ile_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ile_store
// Element memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ile_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [AW-1:0]                     waddr,
  input  wire logic signed [ile_pkg::VAL_W-1:0]  wdata,
  input  wire logic                              re,
  input  wire logic [AW-1:0]                     raddr,
  output      logic signed [ile_pkg::VAL_W-1:0]  rdata
);
  import ile_pkg::*;

  logic signed [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_indexed_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_engine
// Self-checking bench for the indexed list engine.
// ----------------------------------------------------------------------------
// A table of directed command words runs first: empty list, out-of-range
// positions, spare codes and value extremes. Random command words follow
// under four idling patterns on the command and result channels. Each result
// word is checked field by field against the table's expected word or, for
// the rest, against a shadow list that the bench keeps itself.
// ----------------------------------------------------------------------------
module tb_indexed_list_engine;
  import ile_pkg::*;

  localparam int          CLK_PERIOD   = 12;
  localparam int          LIST_CAP     = 1024;
  localparam int unsigned CYCLE_LIMIT  = 8_000_000;
  localparam int          DRAIN_CYCLES = 64;
  localparam int          PHASE_WORDS  = 139;

  localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  typedef struct {
    in_word_t  cmd_word;
    bit        typed;
    out_word_t want;
  } probe_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  logic signed [VAL_W-1:0] shadow_elem [LIST_CAP];
  int unsigned             shadow_len = 0;

  out_word_t   pending_results [$];
  probe_t      probes [$];
  out_word_t   front;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  int unsigned words_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned peak_len      = 0;
  int unsigned full_drops    = 0;
  int unsigned range_skips   = 0;

  int unsigned phase_send  [4] = '{0, 82, 0, 26};
  int unsigned phase_stall [4] = '{0, 0, 82, 26};

  indexed_list_engine #(
    .CAPACITY(LIST_CAP)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [ST_W-1:0] place_value(int unsigned p,
                                                  logic signed [VAL_W-1:0] v);
    if (p > shadow_len) return ST_RANGE;
    if (shadow_len >= LIST_CAP) return ST_FULL;
    for (int unsigned i = shadow_len; i > p; i--) shadow_elem[i] = shadow_elem[i - 1];
    shadow_elem[p] = v;
    shadow_len++;
    return ST_DONE;
  endfunction

  function automatic out_word_t apply_command(in_word_t w);
    out_word_t   r;
    int unsigned p;
    r.read_value = -1;
    r.hit        = 1'b0;
    r.status     = ST_DONE;
    p            = w.position;
    case (w.cmd)
      CMD_GET: begin
        if (p < shadow_len) begin
          r.read_value = shadow_elem[p];
          r.hit        = 1'b1;
        end else begin
          r.status = ST_RANGE;
        end
      end
      CMD_HEAD: r.status = place_value(0, w.value);
      CMD_TAIL: r.status = place_value(shadow_len, w.value);
      CMD_AT:   r.status = place_value(p, w.value);
      CMD_DEL: begin
        if (p < shadow_len) begin
          for (int unsigned i = p; i + 1 < shadow_len; i++)
            shadow_elem[i] = shadow_elem[i + 1];
          shadow_len--;
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: r.status = ST_RANGE;
    endcase
    r.length = LEN_W'(shadow_len);
    return r;
  endfunction

  function automatic in_word_t random_command();
    in_word_t    w;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30)      w.cmd = CMD_GET;
    else if (roll < 42) w.cmd = CMD_HEAD;
    else if (roll < 54) w.cmd = CMD_TAIL;
    else if (roll < 70) w.cmd = CMD_AT;
    else if (roll < 96) w.cmd = CMD_DEL;
    else begin
      case ($urandom_range(2))
        0:       w.cmd = CMD_SPARE5;
        1:       w.cmd = CMD_SPARE6;
        default: w.cmd = CMD_SPARE7;
      endcase
    end
    case ($urandom_range(9))
      0:       w.value = 32'h7FFF_FFFF;
      1:       w.value = 32'h8000_0000;
      2:       w.value = -1;
      3:       w.value = 0;
      default: w.value = $urandom();
    endcase
    roll = $urandom_range(99);
    if (roll < 45)      w.position = POS_W'($urandom_range(shadow_len));
    else if (roll < 60) w.position = POS_W'(shadow_len);
    else if (roll < 75) w.position = POS_W'($urandom_range(3));
    else if (roll < 88)
      w.position = POS_W'((shadow_len > 2 ? shadow_len - 2 : 0) + $urandom_range(4));
    else                w.position = POS_W'($urandom_range(2047));
    return w;
  endfunction

  task automatic add_probe(logic [CMD_W-1:0] cmd, int unsigned pos, logic [VAL_W-1:0] val,
                           bit typed, logic [VAL_W-1:0] rd, logic hit,
                           logic [ST_W-1:0] st, int unsigned len);
    probe_t pr;
    pr.cmd_word.cmd      = cmd;
    pr.cmd_word.position = POS_W'(pos);
    pr.cmd_word.value    = val;
    pr.typed             = typed;
    pr.want.read_value   = rd;
    pr.want.hit          = hit;
    pr.want.status       = st;
    pr.want.length       = LEN_W'(len);
    probes.push_back(pr);
  endtask

  // Enter and leave at a falling edge; valid stays high for a back-to-back word.
  task automatic push_word(in_word_t w, bit typed, out_word_t want);
    out_word_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = apply_command(w);
    pending_results.push_back(typed ? want : pred);
    words_sent++;
    if (shadow_len > peak_len) peak_len = shadow_len;
    if (pred.status == ST_FULL) full_drops++;
    if (pred.status == ST_RANGE) range_skips++;
    @(negedge clk);
  endtask

  always @(negedge clk) out_ready = rst ? 1'b0 : ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: value %0d hit %0b status %0d length %0d",
                   out_data.read_value, out_data.hit, out_data.status, out_data.length);
      end else begin
        front = pending_results.pop_front();
        if (out_data.read_value !== front.read_value || out_data.hit !== front.hit ||
            out_data.status !== front.status || out_data.length !== front.length) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected value %0d hit %0b status %0d length %0d",
                     results_seen, front.read_value, front.hit, front.status,
                     front.length);
            $display("  got value %0d hit %0b status %0d length %0d",
                     out_data.read_value, out_data.hit, out_data.status, out_data.length);
          end
        end
      end
      results_seen++;
    end
  end

  initial begin
    // cmd, position, value, typed, read_value, hit, status, length
    add_probe(CMD_GET,    0,    0,             1, -1,            0, ST_RANGE, 0);
    add_probe(CMD_DEL,    0,    0,             1, -1,            0, ST_RANGE, 0);
    add_probe(CMD_AT,     1,    5,             1, -1,            0, ST_RANGE, 0);
    add_probe(CMD_AT,     0,    32'h7FFF_FFFF, 1, -1,            0, ST_DONE,  1);
    add_probe(CMD_HEAD,   0,    32'h8000_0000, 1, -1,            0, ST_DONE,  2);
    add_probe(CMD_TAIL,   2047, -1,            1, -1,            0, ST_DONE,  3);
    add_probe(CMD_AT,     3,    0,             1, -1,            0, ST_DONE,  4);
    add_probe(CMD_AT,     2,    12345,         1, -1,            0, ST_DONE,  5);
    add_probe(CMD_GET,    0,    0,             1, 32'h8000_0000, 1, ST_DONE,  5);
    add_probe(CMD_GET,    4,    0,             1, 0,             1, ST_DONE,  5);
    add_probe(CMD_GET,    3,    0,             1, -1,            1, ST_DONE,  5);
    add_probe(CMD_GET,    5,    0,             1, -1,            0, ST_RANGE, 5);
    add_probe(CMD_GET,    2047, -1,            1, -1,            0, ST_RANGE, 5);
    add_probe(CMD_SPARE5, 1,    7,             1, -1,            0, ST_RANGE, 5);
    add_probe(CMD_SPARE6, 0,    7,             1, -1,            0, ST_RANGE, 5);
    add_probe(CMD_SPARE7, 2047, -1,            1, -1,            0, ST_RANGE, 5);
    add_probe(CMD_DEL,    5,    0,             1, -1,            0, ST_RANGE, 5);
    add_probe(CMD_DEL,    2047, 0,             1, -1,            0, ST_RANGE, 5);
    add_probe(CMD_DEL,    0,    0,             0, 0,             0, ST_DONE,  0);
    add_probe(CMD_DEL,    3,    0,             0, 0,             0, ST_DONE,  0);
    add_probe(CMD_GET,    1,    0,             0, 0,             0, ST_DONE,  0);
    add_probe(CMD_AT,     1024, 99,            1, -1,            0, ST_RANGE, 3);
    add_probe(CMD_AT,     1,    32'h5A5A_0F0F, 0, 0,             0, ST_DONE,  0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (probes[i]) push_word(probes[i].cmd_word, probes[i].typed, probes[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_send[ph];
      stall_pct     = phase_stall[ph];
      repeat (PHASE_WORDS) push_word(random_command(), 1'b0, '0);
    end

    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d command words and %0d result words in %0d cycles",
             words_sent, results_seen, cycle_count);
    $display("longest list %0d, %0d inserts dropped while full, %0d commands out of range",
             peak_len, full_drops, range_skips);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatching result words", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
